@@ src/assert_macros.svh @@
// assert_macros.svh - assertion helpers for the pose integrator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/tpi_pkg.sv @@
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types, constants and tables of the trapezoid pose integrator.
// ----------------------------------------------------------------------------
package tpi_pkg;
  localparam int PeriodW = 24;
  localparam logic [23:0] PeriodReset = 24'd167772;
  localparam logic signed [33:0] PiQ = 34'sd1686629713;
  localparam logic signed [34:0] TwoPiQ = 35'sd3373259426;
  localparam logic signed [33:0] HalfPiQ = 34'sd843314857;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [37:0] RateLimit = 38'sd68719476736;
  localparam int CordicSteps = 30;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV1, ST_DIV2, ST_COR1, ST_COR2, ST_VEL, ST_HEAD,
    ST_POS, ST_WRAP, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIV1_START, OP_DIV2_START, OP_COR1_START,
    OP_COR2_START, OP_VEL, OP_HEAD, OP_POS, OP_WRAP, OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t op;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cor_done;
    logic wrap_done;
  } stat_t;

  function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 32'sd421657428;
      5'd1: atan_lut = 32'sd248918915;
      5'd2: atan_lut = 32'sd131521918;
      5'd3: atan_lut = 32'sd66762579;
      5'd4: atan_lut = 32'sd33510843;
      5'd5: atan_lut = 32'sd16771758;
      5'd6: atan_lut = 32'sd8387925;
      5'd7: atan_lut = 32'sd4194219;
      5'd8: atan_lut = 32'sd2097141;
      5'd9: atan_lut = 32'sd1048575;
      default: atan_lut = 32'sd1 <<< (5'd29 - i);
    endcase
  endfunction
endpackage

@@ src/tpi_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpi_ctrl
// Sequencer: issues datapath commands for one tick, waits on the
// iterative units and holds the result until taken.
// ----------------------------------------------------------------------------
module tpi_ctrl import tpi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  out_fire,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_DIV1;
      ST_DIV1: if (stat.div_done) state_nxt = ST_DIV2;
      ST_DIV2: if (stat.div_done) state_nxt = ST_COR1;
      ST_COR1: if (stat.cor_done) state_nxt = ST_COR2;
      ST_COR2: if (stat.cor_done) state_nxt = ST_VEL;
      ST_VEL:  state_nxt = ST_HEAD;
      ST_HEAD: state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_WRAP;
      ST_WRAP: if (stat.wrap_done) state_nxt = ST_DONE;
      ST_DONE: if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // start pulse on entry; units run while step is high
  always_comb begin
    cmd.op = OP_NONE;
    cmd.step = 1'b0;
    case (state_r)
      ST_IDLE: if (in_fire) cmd.op = OP_LOAD;
      ST_DIV1: begin
        cmd.step = 1'b1;
        if (stat.div_done) cmd.op = OP_DIV2_START;
      end
      ST_DIV2: begin
        cmd.step = 1'b1;
        if (stat.div_done) cmd.op = OP_COR1_START;
      end
      ST_COR1: begin
        cmd.step = 1'b1;
        if (stat.cor_done) cmd.op = OP_COR2_START;
      end
      ST_COR2: begin
        cmd.step = 1'b1;
        if (stat.cor_done) cmd.op = OP_VEL;
      end
      ST_VEL:  cmd.op = OP_HEAD;
      ST_HEAD: cmd.op = OP_POS;
      ST_POS:  cmd.op = OP_WRAP;
      // one wrap round per cycle until the heading is back in range
      ST_WRAP: cmd.op = stat.wrap_done ? OP_COMMIT : OP_WRAP;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
endmodule

@@ src/tpi_datapath.sv @@
// ----------------------------------------------------------------------------
// tpi_datapath
// History registers, shared radix-2 divider, shared CORDIC, multiply and
// saturate steps of the pose update.
// ----------------------------------------------------------------------------
module tpi_datapath import tpi_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output stat_t                       stat,
  input  logic [PeriodW-1:0]          period,
  input  logic signed [31:0]          accel_in,
  input  logic signed [31:0]          radius_in,
  output logic signed [31:0]          accel_out,
  output logic signed [31:0]          velocity_out,
  output logic signed [31:0]          heading_out,
  output logic signed [47:0]          x_out,
  output logic signed [47:0]          y_out
);
  // history
  logic signed [31:0] a_old_r, v_prev_r, v_old_r, p_prev_r, p_old_r, r_old_r;
  logic signed [47:0] x_prev_r, y_prev_r;
  logic signed [31:0] a_new_r, r_new_r;

  // divider: |v|<<29 / |r|, 61-bit dividend
  logic [60:0] dq_r;
  logic [31:0] drem_r;
  logic [32:0] dden_r;
  logic        dneg_r, dzero_r;
  logic [5:0]  cnt_r;
  logic signed [37:0] q1_r, q2_r;

  // cordic
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic        cneg_r;
  logic signed [31:0] c1_r, s1_r, c2_r, s2_r;

  // results
  logic signed [31:0] v_r;
  logic signed [37:0] p_r;
  logic signed [47:0] x_r, y_r;
  logic signed [41:0] cxs_r, cys_r;

  function automatic logic signed [37:0] sat_rate(input logic [60:0] mag,
                                                   input logic neg);
    logic signed [37:0] res;
    if (mag > 61'(RateLimit)) res = neg ? -RateLimit : RateLimit;
    else res = neg ? -$signed(mag[37:0]) : $signed(mag[37:0]);
    return res;
  endfunction

  // divider setup
  logic signed [31:0] dv_sel, dr_sel;
  logic [31:0] dv_abs;
  logic [32:0] dr_abs;
  logic [32:0] trial;
  assign dv_sel = (cmd.op == OP_LOAD) ? v_prev_r : v_old_r;
  assign dr_sel = (cmd.op == OP_LOAD) ? radius_in : r_old_r;
  assign dv_abs = dv_sel[31] ? 32'(-dv_sel) : 32'(dv_sel);
  assign dr_abs = dr_sel[31] ? 33'(-34'(dr_sel)) : 33'(dr_sel);
  assign trial = {drem_r, dq_r[60]} - dden_r;

  // cordic setup and step
  logic signed [31:0] ang_sel;
  logic signed [33:0] ang_w;
  logic signed [33:0] xs, ys;
  logic signed [31:0] at;
  assign ang_sel = (cmd.op == OP_COR2_START) ? p_old_r : p_prev_r;
  assign xs = cx_r >>> cnt_r[4:0];
  assign ys = cy_r >>> cnt_r[4:0];
  assign at = atan_lut(cnt_r[4:0]);

  // multiplies
  logic signed [32:0] asum;
  logic signed [57:0] vprod;
  logic signed [31:0] vnew_w;
  logic signed [38:0] qsum;
  logic signed [63:0] pprod;
  logic signed [63:0] mc1, ms1, mc2, ms2;
  logic signed [40:0] tc1, ts1, tc2, ts2;
  logic signed [41:0] cxs, cys;
  logic signed [66:0] xprod, yprod;
  logic signed [49:0] xsum, ysum;
  logic signed [37:0] pw;

  assign asum = 33'(a_new_r) + 33'(a_old_r);
  assign vprod = asum * $signed({1'b0, period});
  assign qsum = 39'(q1_r) + 39'(q2_r);
  assign pprod = 64'(qsum) * 64'($signed({1'b0, period}));
  assign mc1 = v_prev_r * c1_r;
  assign ms1 = v_prev_r * s1_r;
  assign mc2 = v_old_r * c2_r;
  assign ms2 = v_old_r * s2_r;
  assign tc1 = 41'((mc1 + 64'sd8388608) >>> 24);
  assign ts1 = 41'((ms1 + 64'sd8388608) >>> 24);
  assign tc2 = 41'((mc2 + 64'sd8388608) >>> 24);
  assign ts2 = 41'((ms2 + 64'sd8388608) >>> 24);
  assign cxs = 42'(tc1) + 42'(tc2);
  assign cys = 42'(ts1) + 42'(ts2);
  // trig sums are registered in the cycle before the position multiply
  assign xprod = 67'(cxs_r) * 67'($signed({1'b0, period}));
  assign yprod = 67'(cys_r) * 67'($signed({1'b0, period}));
  assign xsum = 50'(x_prev_r) + 50'((xprod + 67'sd1073741824) >>> 31);
  assign ysum = 50'(y_prev_r) + 50'((yprod + 67'sd1073741824) >>> 31);

  always_comb begin
    logic signed [33:0] t;
    t = 34'(v_prev_r) + 34'((vprod + 58'sd16777216) >>> 25);
    if (t > 34'sd2147483647) vnew_w = 32'h7fffffff;
    else if (t < -34'sd2147483648) vnew_w = 32'h80000000;
    else vnew_w = t[31:0];
  end

  // p in [-pi,pi) plus |dp| up to 2^36: one 2*pi round per cycle
  always_comb begin
    pw = p_r;
    if (pw >= 38'(PiQ)) pw = pw - 38'(TwoPiQ);
    else if (pw < -38'(PiQ)) pw = pw + 38'(TwoPiQ);
  end

  always_comb begin
    if (ang_sel > 32'(HalfPiQ)) ang_w = 34'(ang_sel) - PiQ;
    else if (ang_sel < -32'(HalfPiQ)) ang_w = 34'(ang_sel) + PiQ;
    else ang_w = 34'(ang_sel);
  end

  assign stat.div_done = (cnt_r == 6'd61);
  assign stat.cor_done = (cnt_r == 6'd30);
  assign stat.wrap_done = (p_r >= -38'(PiQ)) && (p_r < 38'(PiQ));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_old_r <= '0; v_prev_r <= '0; v_old_r <= '0; p_prev_r <= '0;
      p_old_r <= '0; r_old_r <= '0; x_prev_r <= '0; y_prev_r <= '0;
      cnt_r <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD, OP_DIV2_START: begin
          if (cmd.op == OP_LOAD) begin
            a_new_r <= accel_in;
            r_new_r <= radius_in;
          end else begin
            q1_r <= dzero_r ? 38'sd0 : sat_rate(dq_r, dneg_r);
          end
          dq_r <= {dv_abs, 29'd0};
          drem_r <= '0;
          dden_r <= dr_abs;
          dneg_r <= dv_sel[31] ^ dr_sel[31];
          dzero_r <= (dr_sel == 32'sd0);
          cnt_r <= '0;
        end
        OP_COR1_START, OP_COR2_START: begin
          if (cmd.op == OP_COR1_START) q2_r <= dzero_r ? 38'sd0 : sat_rate(dq_r, dneg_r);
          else begin
            c1_r <= cneg_r ? 32'(-cx_r) : 32'(cx_r);
            s1_r <= cneg_r ? 32'(-cy_r) : 32'(cy_r);
          end
          cx_r <= CordicGain;
          cy_r <= '0;
          cz_r <= ang_w;
          cneg_r <= (ang_w != 34'(ang_sel));
          cnt_r <= '0;
        end
        OP_VEL: begin
          c2_r <= cneg_r ? 32'(-cx_r) : 32'(cx_r);
          s2_r <= cneg_r ? 32'(-cy_r) : 32'(cy_r);
          v_r <= vnew_w;
        end
        OP_HEAD: begin
          p_r <= 38'(p_prev_r) + 38'((pprod + 64'sd16777216) >>> 25);
          cxs_r <= cxs;
          cys_r <= cys;
        end
        OP_POS: begin
          x_r <= (xsum > 50'(48'sh7fffffffffff)) ? 48'sh7fffffffffff :
                 (xsum < -50'sh800000000000) ? 48'sh800000000000 : xsum[47:0];
          y_r <= (ysum > 50'(48'sh7fffffffffff)) ? 48'sh7fffffffffff :
                 (ysum < -50'sh800000000000) ? 48'sh800000000000 : ysum[47:0];
          p_r <= pw;
        end
        OP_WRAP: p_r <= pw;
        OP_COMMIT: begin
          a_old_r <= a_new_r;
          r_old_r <= r_new_r;
          v_old_r <= v_prev_r;
          v_prev_r <= v_r;
          p_old_r <= p_prev_r;
          p_prev_r <= 32'(p_r);
          x_prev_r <= x_r;
          y_prev_r <= y_r;
        end
        default: begin
          if (cmd.step) begin
            cnt_r <= cnt_r + 6'd1;
            // divider restoring step (both divider states share this path)
            if (!trial[32]) begin
              drem_r <= trial[31:0];
              dq_r <= {dq_r[59:0], 1'b1};
            end else begin
              drem_r <= {drem_r[30:0], dq_r[60]};
              dq_r <= {dq_r[59:0], 1'b0};
            end
            if (!cz_r[33]) begin
              cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - 34'(at);
            end else begin
              cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + 34'(at);
            end
          end
        end
      endcase
    end
  end

  assign accel_out = a_new_r;
  assign velocity_out = v_r;
  assign heading_out = 32'(p_r);
  assign x_out = x_r;
  assign y_out = y_r;
endmodule

@@ src/trapezoid_pose_integrator_core.sv @@
// ----------------------------------------------------------------------------
// trapezoid_pose_integrator_core
// Trapezoid-rule dead reckoning of speed, heading and planar position.
// ----------------------------------------------------------------------------
// One item at a time: the result is valid after two 61-step divisions for
// the yaw-rate terms through one shared divider and two 30-step CORDIC runs
// through one shared CORDIC unit, plus the velocity, heading, position and
// wrap updates. When the heading step spans many turns the wrap repeats, one
// 2*pi round at a time, until the heading is back in range. The result holds
// until taken; the next input is accepted from the cycle after it is taken.
// Configuration writes are accepted only while idle.
module trapezoid_pose_integrator_core import tpi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data,      // sample_period
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,      // accel_in[31:0], radius_in[63:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata      // accel, velocity, heading, x[47:0], y[47:0]
);
`include "assert_macros.svh"
  logic [PeriodW-1:0] period_r;
  cmd_t  cmd;
  stat_t stat;
  logic  busy, in_fire, out_fire;
  logic signed [31:0] a_o, v_o, h_o;
  logic signed [47:0] x_o, y_o;

  assign cfg_ready = !busy;
  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) period_r <= PeriodReset;
    else if (cfg_valid && cfg_ready) period_r <= cfg_data;
  end

  tpi_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_fire, .stat, .cmd, .busy,
    .out_valid(out_tvalid));

  tpi_datapath u_dp (.clk, .rst_n, .cmd, .stat, .period(period_r),
    .accel_in(in_tdata[31:0]), .radius_in(in_tdata[63:32]),
    .accel_out(a_o), .velocity_out(v_o), .heading_out(h_o),
    .x_out(x_o), .y_out(y_o));

  assign out_tdata = {y_o, x_o, h_o, v_o, a_o};

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, out_tvalid, !in_tready)
  `ASSERT_NEXT(a_out_held, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_start, clk, rst_n, in_fire, !in_tready && !out_tvalid)
endmodule

@@ verif/tpi_checker.sv @@
// ----------------------------------------------------------------------------
// tpi_checker
// Watches the configuration, input and result channels of the pose integrator
// core, predicts every result from its own copy of the integrator state and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tpi_checker import tpi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [23:0]  cfg_data,      // sample_period
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [63:0]  in_tdata,      // accel_in[31:0], radius_in[63:32]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,     // accel, velocity, heading, x[47:0], y[47:0]
  output int           err_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // lowest field in the lowest bits, so y sits on top
  typedef struct packed {
    logic [47:0] y;
    logic [47:0] x;
    logic [31:0] heading;
    logic [31:0] velocity;
    logic [31:0] accel;
  } pose_t;

  pose_t pose_q[$];

  longint period;
  longint acc_old, vel_new, vel_old, hd_new, hd_old, rad_old, xpos, ypos;

  function automatic longint round_sh(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint yaw_rate(longint v, longint r);
    if (r == 0) return 0;
    return sat((v * 64'sd536870912) / r, -longint'(RateLimit), longint'(RateLimit));
  endfunction

  task automatic cordic(input longint ang, output longint c, output longint s);
    bit     fold;
    longint cx, cy, z, xs, ys;
    fold = 0;
    cx = longint'(CordicGain);
    cy = 0;
    if (ang > longint'(HalfPiQ)) begin
      ang -= longint'(PiQ);
      fold = 1;
    end else if (ang < -longint'(HalfPiQ)) begin
      ang += longint'(PiQ);
      fold = 1;
    end
    z = ang;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx -= ys; cy += xs; z -= longint'(atan_lut(i[4:0]));
      end else begin
        cx += ys; cy -= xs; z += longint'(atan_lut(i[4:0]));
      end
    end
    c = fold ? -cx : cx;
    s = fold ? -cy : cy;
  endtask

  task automatic integrate(input logic [63:0] item, output pose_t res);
    longint a1, r1, v, p, q, c1, s1, c2, s2, cx, cy, xn, yn;
    a1 = longint'(signed'(item[31:0]));
    r1 = longint'(signed'(item[63:32]));
    v = sat(vel_new + round_sh((a1 + acc_old) * period, 25),
            -64'sd2147483648, 64'sd2147483647);
    q = yaw_rate(vel_new, r1) + yaw_rate(vel_old, rad_old);
    p = hd_new + round_sh(q * period, 25) + longint'(PiQ);
    p = p % longint'(TwoPiQ);
    if (p < 0) p += longint'(TwoPiQ);
    p -= longint'(PiQ);
    cordic(hd_new, c1, s1);
    cordic(hd_old, c2, s2);
    cx = round_sh(vel_new * c1, 24) + round_sh(vel_old * c2, 24);
    cy = round_sh(vel_new * s1, 24) + round_sh(vel_old * s2, 24);
    xn = sat(xpos + round_sh(cx * period, 31), -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    yn = sat(ypos + round_sh(cy * period, 31), -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    res.accel = a1[31:0];
    res.velocity = v[31:0];
    res.heading = p[31:0];
    res.x = xn[47:0];
    res.y = yn[47:0];
    acc_old = a1;
    rad_old = r1;
    vel_old = vel_new;
    vel_new = v;
    hd_old = hd_new;
    hd_new = p;
    xpos = xn;
    ypos = yn;
  endtask

  task automatic report(input string name, input logic [47:0] want, input logic [47:0] got);
    err_count++;
    if (err_count <= 10)
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
  endtask

  assign pending = pose_q.size();

  always @(posedge clk) begin
    pose_t p_new, want, got;
    if (!rst_n) begin
      period = longint'(PeriodReset);
      acc_old = 0; vel_new = 0; vel_old = 0; hd_new = 0; hd_old = 0;
      rad_old = 0; xpos = 0; ypos = 0;
      pose_q.delete();
      err_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) period = longint'(cfg_data);
      if (in_tvalid && in_tready) begin
        integrate(in_tdata, p_new);
        pose_q.push_back(p_new);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pose_q.size() == 0) begin
          report("unexpected transaction", 48'h0, got.accel);
        end else begin
          want = pose_q.pop_front();
          if (got.accel !== want.accel) report("accel", want.accel, got.accel);
          if (got.velocity !== want.velocity)
            report("velocity", want.velocity, got.velocity);
          if (got.heading !== want.heading) report("heading", want.heading, got.heading);
          if (got.x !== want.x) report("x", want.x, got.x);
          if (got.y !== want.y) report("y", want.y, got.y);
        end
      end
    end
  end
endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the pose integrator core: directed extremes, then
// random ticks over several sample periods and backpressure patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [23:0]  cfg_data = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [191:0] out_tdata;
  int           err_count, pending;

  int tx_idle_pct = 7;
  int rx_idle_pct = 78;
  int hold_cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  trapezoid_pose_integrator_core i_dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata
  );

  tpi_checker i_checker (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata,
    .err_count, .pending
  );

  // receiver; a long hold-off lets the core fill up and block its input
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_tick(input logic [31:0] accel, input logic [31:0] radius);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {radius, accel};
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_accel();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'h0;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h80000)
                                           : -$urandom_range(0, 32'h80000);
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(0, 9))
      0, 1: return 32'h0;                                    // straight
      2: return $urandom();
      3: return $urandom_range(0, 1) ? $urandom_range(1, 255)  // huge rate
                                     : -$urandom_range(1, 255);
      4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 1) ? $urandom_range(32'h10000, 32'h2000000)
                                           : -$urandom_range(32'h10000, 32'h2000000);
    endcase
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_period(input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [23:0] periods[6];
    periods = '{24'hffffff, 24'd1, 24'd0, 24'd167772, 24'h0, 24'd167772};
    periods[4] = 24'($urandom());
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of both fields at reset period
    send_tick(32'h7fffffff, 32'h0);
    send_tick(32'h7fffffff, 32'h1);
    send_tick(32'h7fffffff, 32'hffffffff);
    send_tick(32'h80000000, 32'h7fffffff);
    send_tick(32'h80000000, 32'h80000000);
    send_tick(32'h0, 32'h10000);
    send_tick(32'h00010000, 32'hffff0000);
    send_tick(32'hffffffff, 32'h1);
    send_tick(32'h0, 32'h0);
    send_tick(32'h00100000, 32'h00000100);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 78 : 0;
      rx_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 7 : 0;
      if (ph == 2) write_period(24'hffffff);
      write_period(periods[ph]);
      for (int n = 0; n < 115; n++) begin
        if (ph == 1 && n == 20) hold_cycles <= 800;
        send_tick(rand_accel(), rand_radius());
      end
      drain();
    end

    if (err_count == 0 && pending == 0) begin
      $display("trapezoid_pose_integrator_core test passed");
    end else begin
      $display("trapezoid_pose_integrator_core test failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("trapezoid_pose_integrator_core test failed");
    $finish;
  end
endmodule
